/* rtl/tmmi_pkg.sv */
package tmmi_pkg;

  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DATA_W     = 32;
  localparam int NUM_W      = 61;   // (coord diff) << 26 or (Q4.28) << 28, signed
  localparam int DEN_W      = 34;   // span or pivot, signed
  localparam int ITER_W     = $clog2(NUM_W);

  localparam logic signed [31:0] Q_ONE     = 32'sh1000_0000;
  localparam logic signed [31:0] Q_QUARTER = 32'sh0400_0000;
  localparam logic signed [31:0] Q_DIAG    = 32'sh0C00_0000;
  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_COLUMN = 1'b1;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_RANGE    = 2'd1;
  localparam logic [1:0] ERR_SINGULAR = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CA, S_CB, S_CC, S_CD,
    S_CLO_GO, S_CLO_W, S_CUP_GO, S_CUP_W,
    S_FRD, S_FM1, S_FM2, S_FM3, S_FM4, S_FM5,
    S_FU_GO, S_FU_W, S_FR_GO, S_FR_W,
    S_BRD, S_BM1, S_BM2, S_BWR,
    S_ERD, S_ELD, S_EW
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

  // saturate a 33-bit signed difference to Q4.28
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) return Q_MAX;
    else if (v < -33'sh0_8000_0000) return Q_MIN;
    else return v[31:0];
  endfunction

  // Q4.28 product scaling: truncate toward zero, saturate
  function automatic logic signed [31:0] qtrunc(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [35:0] q;
    logic [35:0] nq;
    mag = p[63] ? 64'(-p) : 64'(p);
    q   = mag[63:28];
    nq  = -q;
    if (p[63]) begin
      if (q > 36'h0_8000_0000) return Q_MIN;
      else return nq[31:0];
    end else begin
      if (q > 36'h0_7FFF_FFFF) return Q_MAX;
      else return q[31:0];
    end
  endfunction

endpackage

/* rtl/tmmi_in_if.sv */
interface tmmi_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] grid_point;
  logic        final_point;
  logic [4:0]  column_index;

  modport source(output valid, command, grid_point, final_point, column_index,
                 input ready);
  modport sink(input valid, command, grid_point, final_point, column_index,
               output ready);
endinterface

/* rtl/tmmi_out_if.sv */
interface tmmi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] entry_value;
  logic [4:0]  row_index;
  logic        column_end;
  logic [1:0]  error_code;

  modport source(output valid, entry_value, row_index, column_end, error_code,
                 input ready);
  modport sink(input valid, entry_value, row_index, column_end, error_code,
               output ready);
endinterface

/* rtl/tmmi_div.sv */
module tmmi_div (
  input  logic              clk,
  input  logic              rst,
  input  tmmi_pkg::div_req_t req,
  output tmmi_pkg::div_rsp_t rsp
);
  import tmmi_pkg::*;

  // restoring divider, one quotient bit per cycle, truncates toward zero
  logic              busy;
  logic              done;
  logic [ITER_W-1:0] cnt;
  logic              neg;
  logic [DEN_W-2:0]  den_mag;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;

  logic [NUM_W-1:0]  num_mag;
  logic [DEN_W-2:0]  den_abs;
  logic [DEN_W-1:0]  rem_sh;
  logic              ge;
  logic [NUM_W-1:0]  nquo;

  always_comb begin
    num_mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    den_abs = req.den[DEN_W-1] ? (DEN_W-1)'(-req.den) : (DEN_W-1)'(req.den);
    rem_sh  = {rem[DEN_W-2:0], quo[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_mag};
    nquo    = -quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy    <= 1'b1;
        cnt     <= ITER_W'(NUM_W - 1);
        neg     <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
        den_mag <= den_abs;
        rem     <= '0;
        quo     <= num_mag;
      end else if (busy) begin
        rem <= ge ? rem_sh - {1'b0, den_mag} : rem_sh;
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    if (neg) begin
      if (quo > NUM_W'(33'h0_8000_0000)) rsp.quo = Q_MIN;
      else rsp.quo = nquo[DATA_W-1:0];
    end else begin
      if (quo > NUM_W'(33'h0_7FFF_FFFF)) rsp.quo = Q_MAX;
      else rsp.quo = quo[DATA_W-1:0];
    end
  end

endmodule

/* rtl/tridiagonal_mass_matrix_inverse.sv */
// Channel  Modport  Direction  Transfer moves
// -------  -------  ---------  ---------------------------------------------
// cmd      sink     in         command, grid_point, final_point, column_index
// result   source   out        entry_value, row_index, column_end, error_code
//
// A column request over N points computes the coefficients of the interior points,
// runs the forward sweep and the back substitution, then emits one entry per point;
// every division goes through the shared divider.
// An error answer comes after the check that finds it.
// rst is synchronous, active high; it clears the point count and load flag.
// cmd.ready is high only while idle; a stalled result holds in its register.
module tridiagonal_mass_matrix_inverse (
  input logic        clk,
  input logic        rst,
  tmmi_in_if.sink    cmd,
  tmmi_out_if.source result
);
  import tmmi_pkg::*;

  state_t state, state_next;

  // load state
  logic [CNT_W-1:0] point_count;
  logic             load_complete;

  // sequencer datapath
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  col;
  logic signed [31:0] left, mid, right;
  logic signed [31:0] lo_r, up_r, piv, rhs, su_r, prev_su, prev_sr, d_r, qm;
  logic signed [63:0] prod;

  // output register
  logic        out_valid;
  logic [31:0] out_value;
  logic [4:0]  out_row;
  logic        out_end;
  logic [1:0]  out_err;

  // memories
  logic signed [31:0] grid_mem [MAX_POINTS];
  logic signed [31:0] lo_mem   [MAX_POINTS];
  logic signed [31:0] up_mem   [MAX_POINTS];
  logic signed [31:0] su_mem   [MAX_POINTS];
  logic signed [31:0] sr_mem   [MAX_POINTS];
  logic signed [31:0] grid_rd, lo_rd, up_rd, su_rd, sr_rd;

  logic              grid_we, lo_we, up_we, su_we, sr_we;
  logic [IDX_W-1:0]  grid_wa, grid_ra;
  logic signed [31:0] sr_wd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [31:0] mul_a, mul_b;

  // derived values
  logic [CNT_W-1:0]   load_base;
  logic [CNT_W-1:0]   np_m1;
  logic               is_last;
  logic               req_bad;
  logic signed [32:0] span, dl, dr;
  logic signed [31:0] lo_val, e_val;
  logic               accept_in;

  tmmi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    accept_in = cmd.valid && cmd.ready;
    load_base = load_complete ? '0 : point_count;
    np_m1     = point_count - 1'b1;
    is_last   = {1'b0, idx} == np_m1;
    req_bad   = !load_complete || (point_count < CNT_W'(2)) ||
                ({1'b0, cmd.column_index} >= point_count);
    span      = {right[31], right} - {left[31], left};
    dl        = {mid[31], mid} - {left[31], left};
    dr        = {right[31], right} - {mid[31], mid};
    lo_val    = is_last ? Q_QUARTER : lo_rd;
    e_val     = (idx == col) ? Q_ONE : 32'sd0;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept_in && cmd.command == CMD_COLUMN) begin
          if (req_bad) state_next = S_EW;
          else if (point_count == CNT_W'(2)) state_next = S_FRD;
          else state_next = S_CA;
        end
      end
      S_CA:     state_next = S_CB;
      S_CB:     state_next = S_CC;
      S_CC:     state_next = S_CD;
      S_CD:     state_next = S_CLO_GO;
      S_CLO_GO: state_next = (span == '0) ? S_EW : S_CLO_W;
      S_CLO_W:  if (div_rsp.done) state_next = S_CUP_GO;
      S_CUP_GO: state_next = S_CUP_W;
      S_CUP_W: begin
        if (div_rsp.done)
          state_next = ({1'b0, idx} + CNT_W'(2) < point_count) ? S_CA : S_FRD;
      end
      S_FRD:    state_next = S_FM1;
      S_FM1:    state_next = (idx == '0) ? S_FU_GO : S_FM2;
      S_FM2:    state_next = S_FM3;
      S_FM3:    state_next = S_FM4;
      S_FM4:    state_next = (piv == '0) ? S_EW : S_FM5;
      S_FM5:    state_next = S_FU_GO;
      S_FU_GO:  state_next = is_last ? S_FR_GO : S_FU_W;
      S_FU_W:   if (div_rsp.done) state_next = S_FR_GO;
      S_FR_GO:  state_next = S_FR_W;
      S_FR_W:   if (div_rsp.done) state_next = is_last ? S_BRD : S_FRD;
      S_BRD:    state_next = S_BM1;
      S_BM1:    state_next = S_BM2;
      S_BM2:    state_next = S_BWR;
      S_BWR:    state_next = (idx == '0) ? S_ERD : S_BRD;
      S_ERD:    state_next = S_ELD;
      S_ELD:    state_next = S_EW;
      S_EW: begin
        if (result.ready) state_next = out_end ? S_IDLE : S_ERD;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd.ready     = state == S_IDLE;
    grid_we       = accept_in && cmd.command == CMD_LOAD &&
                    load_base < CNT_W'(MAX_POINTS);
    grid_wa       = load_base[IDX_W-1:0];
    grid_ra       = idx;
    lo_we         = 1'b0;
    up_we         = 1'b0;
    su_we         = 1'b0;
    sr_we         = 1'b0;
    sr_wd         = div_rsp.quo;
    div_req.start = 1'b0;
    div_req.num   = {{(NUM_W-33-26){dl[32]}}, dl, 26'b0};
    div_req.den   = {{(DEN_W-33){span[32]}}, span};
    mul_a         = lo_val;
    mul_b         = prev_su;
    case (state)
      S_CA: grid_ra = idx - 1'b1;
      S_CC: grid_ra = idx + 1'b1;
      S_CLO_GO: div_req.start = span != '0;
      S_CLO_W:  lo_we = div_rsp.done;
      S_CUP_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {{(NUM_W-33-26){dr[32]}}, dr, 26'b0};
      end
      S_CUP_W:  up_we = div_rsp.done;
      S_FM3: begin
        mul_a = lo_r;
        mul_b = prev_sr;
      end
      S_FU_GO: begin
        div_req.start = !is_last;
        div_req.num   = {{(NUM_W-32-28){up_r[31]}}, up_r, 28'b0};
        div_req.den   = {{(DEN_W-32){piv[31]}}, piv};
      end
      S_FR_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {{(NUM_W-32-28){rhs[31]}}, rhs, 28'b0};
        div_req.den   = {{(DEN_W-32){piv[31]}}, piv};
      end
      S_FR_W: begin
        su_we = div_rsp.done;
        sr_we = div_rsp.done;
      end
      S_BM1: begin
        mul_a = su_rd;
        mul_b = prev_sr;
      end
      S_BWR: begin
        sr_we = 1'b1;
        sr_wd = sat33({d_r[31], d_r} - {qm[31], qm});
      end
      default: ;
    endcase
    result.valid       = out_valid;
    result.entry_value = out_value;
    result.row_index   = out_row;
    result.column_end  = out_end;
    result.error_code  = out_err;
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_wa] <= cmd.grid_point;
    grid_rd <= grid_mem[grid_ra];
  end

  always_ff @(posedge clk) begin
    if (lo_we) lo_mem[idx] <= div_rsp.quo;
    lo_rd <= lo_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (up_we) up_mem[idx] <= div_rsp.quo;
    up_rd <= up_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (su_we) su_mem[idx] <= su_r;
    su_rd <= su_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (sr_we) sr_mem[idx] <= sr_wd;
    sr_rd <= sr_mem[idx];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      point_count   <= '0;
      load_complete <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept_in && cmd.command == CMD_LOAD) begin
        point_count   <= (load_base < CNT_W'(MAX_POINTS)) ? load_base + 1'b1 : load_base;
        load_complete <= cmd.final_point;
      end
      if (state_next == S_EW && state != S_EW) out_valid <= 1'b1;
      else if (state == S_EW && result.ready) out_valid <= 1'b0;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        col <= cmd.column_index;
        if (accept_in && cmd.command == CMD_COLUMN) begin
          idx <= (point_count == CNT_W'(2)) ? '0 : IDX_W'(1);
          if (req_bad) begin
            out_value <= '0;
            out_row   <= '0;
            out_end   <= 1'b1;
            out_err   <= ERR_RANGE;
          end
        end
      end
      S_CB: left  <= grid_rd;
      S_CC: mid   <= grid_rd;
      S_CD: right <= grid_rd;
      S_CLO_GO: begin
        if (span == '0) begin
          out_value <= '0;
          out_row   <= '0;
          out_end   <= 1'b1;
          out_err   <= ERR_SINGULAR;
        end
      end
      S_CUP_W: begin
        if (div_rsp.done)
          idx <= ({1'b0, idx} + CNT_W'(2) < point_count) ? idx + 1'b1 : '0;
      end
      S_FM1: begin
        if (idx == '0) begin
          piv  <= Q_DIAG;
          rhs  <= e_val;
          up_r <= Q_QUARTER;
        end else begin
          lo_r <= lo_val;
          up_r <= up_rd;
        end
      end
      S_FM2: qm <= qtrunc(prod);
      S_FM3: piv <= sat33({Q_DIAG[31], Q_DIAG} - {qm[31], qm});
      S_FM4: begin
        qm <= qtrunc(prod);
        if (piv == '0) begin
          out_value <= '0;
          out_row   <= '0;
          out_end   <= 1'b1;
          out_err   <= ERR_SINGULAR;
        end
      end
      S_FM5: rhs <= sat33({e_val[31], e_val} - {qm[31], qm});
      S_FU_GO: if (is_last) su_r <= '0;
      S_FU_W: if (div_rsp.done) su_r <= div_rsp.quo;
      S_FR_W: begin
        if (div_rsp.done) begin
          prev_su <= su_r;
          prev_sr <= div_rsp.quo;
          idx     <= is_last ? idx - 1'b1 : idx + 1'b1;
        end
      end
      S_BM1: d_r <= sr_rd;
      S_BM2: qm <= qtrunc(prod);
      S_BWR: begin
        prev_sr <= sr_wd;
        if (idx != '0) idx <= idx - 1'b1;
      end
      S_ELD: begin
        out_value <= sr_rd;
        out_row   <= 5'(idx);
        out_end   <= is_last;
        out_err   <= ERR_OK;
      end
      S_EW: if (result.ready && !out_end) idx <= idx + 1'b1;
      default: ;
    endcase
  end

  // checks
  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !result.valid)
    else $error("input ready while a result is pending");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.error_code != ERR_OK |->
      result.column_end && result.entry_value == '0 && result.row_index == '0)
    else $error("error result with payload");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count overflow");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

endmodule

/* dv/tmmi_column_checker.sv */
`timescale 1ns / 100ps

module tmmi_column_checker (
  input  logic clk,
  input  logic rst,
  tmmi_in_if   cmd,
  tmmi_out_if  result,
  output int   fails,
  output int   pending,
  output int   checked,
  output int   err_seen
);
  import tmmi_pkg::*;

  typedef struct {
    logic signed [31:0] entry;
    logic [4:0]         row;
    logic               last;
    logic [1:0]         err;
  } entry_t;

  entry_t                   entries_due[$];
  logic signed [31:0]       grid[MAX_POINTS];
  int                       pt_count;
  bit                       set_done;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clip32((a * b) / longint'(Q_ONE));
  endfunction

  function automatic longint fx_div(longint x, longint y);
    return clip32((x * longint'(Q_ONE)) / y);
  endfunction

  function automatic void push_err(logic [1:0] code);
    entry_t e;
    e.entry = '0;
    e.row   = '0;
    e.last  = 1'b1;
    e.err   = code;
    entries_due.push_back(e);
  endfunction

  // Thomas sweep against unit vector col, same Q4.28 rounding as the block
  function automatic void predict_column(int col);
    longint lo[MAX_POINTS], up[MAX_POINTS], su[MAX_POINTS], sr[MAX_POINTS];
    longint piv, rhs, span;
    int n;
    entry_t e;
    n = pt_count;
    if (!set_done || n < 2 || col >= n) begin
      push_err(ERR_RANGE);
      return;
    end
    for (int i = 0; i < n; i++) begin
      lo[i] = 0;
      up[i] = 0;
    end
    up[0]   = longint'(Q_QUARTER);
    lo[n-1] = longint'(Q_QUARTER);
    for (int i = 1; i + 1 < n; i++) begin
      span = longint'(grid[i+1]) - longint'(grid[i-1]);
      if (span == 0) begin
        push_err(ERR_SINGULAR);
        return;
      end
      lo[i] = clip32(((longint'(grid[i]) - longint'(grid[i-1])) * longint'(Q_QUARTER)) / span);
      up[i] = clip32(((longint'(grid[i+1]) - longint'(grid[i])) * longint'(Q_QUARTER)) / span);
    end
    piv   = longint'(Q_DIAG);
    su[0] = fx_div(up[0], piv);
    sr[0] = fx_div(col == 0 ? longint'(Q_ONE) : 0, piv);
    for (int i = 1; i < n; i++) begin
      rhs = (i == col) ? longint'(Q_ONE) : 0;
      piv = clip32(longint'(Q_DIAG) - fx_mul(lo[i], su[i-1]));
      if (piv == 0) begin
        push_err(ERR_SINGULAR);
        return;
      end
      su[i] = (i + 1 < n) ? fx_div(up[i], piv) : 0;
      rhs   = clip32(rhs - fx_mul(lo[i], sr[i-1]));
      sr[i] = fx_div(rhs, piv);
    end
    for (int k = n - 2; k >= 0; k--)
      sr[k] = clip32(sr[k] - fx_mul(su[k], sr[k+1]));
    for (int i = 0; i < n; i++) begin
      e.entry = sr[i][31:0];
      e.row   = i[4:0];
      e.last  = (i + 1 == n);
      e.err   = ERR_OK;
      entries_due.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pt_count <= 0;
      set_done <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      if (cmd.command == CMD_LOAD) begin
        automatic int cnt = set_done ? 0 : pt_count;
        if (cnt < MAX_POINTS) begin
          grid[cnt] = cmd.grid_point;
          cnt++;
        end
        pt_count <= cnt;
        set_done <= set_done ? cmd.final_point : (set_done | cmd.final_point);
      end else begin
        predict_column(int'(cmd.column_index));
      end
    end
  end

  always @(posedge clk) begin
    entry_t e;
    if (!rst && result.valid && result.ready) begin
      if (entries_due.size() == 0) begin
        $error("unexpected result row %0d value %h", result.row_index, result.entry_value);
        fails++;
      end else begin
        e = entries_due.pop_front();
        checked++;
        if (result.error_code != ERR_OK) err_seen++;
        if (result.entry_value !== e.entry) begin
          $error("entry_value expected %h got %h (row %0d)", e.entry, result.entry_value, e.row);
          fails++;
        end
        if (result.row_index !== e.row) begin
          $error("row_index expected %0d got %0d", e.row, result.row_index);
          fails++;
        end
        if (result.column_end !== e.last) begin
          $error("column_end expected %0d got %0d", e.last, result.column_end);
          fails++;
        end
        if (result.error_code !== e.err) begin
          $error("error_code expected %0d got %0d", e.err, result.error_code);
          fails++;
        end
      end
    end
  end

  // sampled each edge into a register, so it can lag the queue
  always @(posedge clk) pending <= entries_due.size();

  initial begin
    fails    = 0;
    checked  = 0;
    err_seen = 0;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import tmmi_pkg::*;

  // quiet-cycle watchdog
  localparam int QUIET_LIMIT = 60000;

  logic clk;
  logic rst;
  tmmi_in_if  cmd();
  tmmi_out_if result();

  int fails, pending, checked, err_seen;
  int snk_idle, src_idle;
  int hold_left;
  bit hold_arm, hold_used;
  int quiet;
  int loads, columns, items;

  tridiagonal_mass_matrix_inverse dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .result (result)
  );

  tmmi_column_checker chk (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .result   (result),
    .fails    (fails),
    .pending  (pending),
    .checked  (checked),
    .err_seen (err_seen)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      hold_left    <= 0;
      hold_used    <= 1'b0;
    end else if (hold_left > 0) begin
      result.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_arm && !hold_used && result.valid) begin
      result.ready <= 1'b0;
      hold_left    <= 600;
      hold_used    <= 1'b1;
    end else begin
      result.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  // watchdog: any transfer on either channel resets the quiet count
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (result.valid && result.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // one transfer on cmd; valid is only dropped by an idle cycle
  task automatic put(logic op, logic [31:0] gp, logic fin, logic [4:0] col);
    bit rdy;
    while ($urandom_range(0, 99) < src_idle) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.command      <= op;
    cmd.grid_point   <= gp;
    cmd.final_point  <= fin;
    cmd.column_index <= col;
    do begin
      @(negedge clk);
      rdy = cmd.ready;
      @(posedge clk);
    end while (!rdy);
    items++;
  endtask

  task automatic send_load(logic [31:0] gp, logic fin);
    put(CMD_LOAD, gp, fin, 5'($urandom));
    loads++;
  endtask

  task automatic send_col(int col);
    put(CMD_COLUMN, $urandom, 1'($urandom), col[4:0]);
    columns++;
  endtask

  // a point set: sorted ramp with mostly small steps, or raw noise
  task automatic rand_set(int n, bit tidy, bit close);
    logic [31:0] x;
    x = $urandom;
    for (int i = 0; i < n; i++) begin
      if (!tidy)
        x = $urandom;
      else if ($urandom_range(0, 9) != 0)
        x = x + $urandom_range(1, 1 << $urandom_range(4, 24));
      send_load(x, close && (i == n - 1));
    end
  endtask

  initial begin
    int n, sel, first_rnd;
    bit big_done;
    cmd.valid        = 1'b0;
    cmd.command      = CMD_LOAD;
    cmd.grid_point   = '0;
    cmd.final_point  = 1'b0;
    cmd.column_index = '0;
    rst      = 1'b1;
    src_idle = 32;
    snk_idle = 72;
    hold_arm = 1'b0;
    big_done = 1'b0;
    loads    = 0;
    columns  = 0;
    items    = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: request with nothing loaded, open set, extremes
    send_col(0);
    send_load(32'h8000_0000, 1'b0);
    send_col(0);
    send_load(32'h7FFF_FFFF, 1'b1);
    send_col(0);
    send_col(1);
    send_col(2);
    send_col(31);
    // single point: too few
    send_load(32'h0, 1'b1);
    send_col(0);
    // outer points equal: zero span
    send_load(32'h0, 1'b0);
    send_load(32'h0001_0000, 1'b0);
    send_load(32'h0, 1'b1);
    send_col(1);
    // uneven 4-point grid, every column
    send_load(32'hFFFD_0000, 1'b0);
    send_load(32'hFFFF_0000, 1'b0);
    send_load(32'h0, 1'b0);
    send_load(32'h0005_0000, 1'b1);
    for (int c = 0; c < 4; c++) send_col(c);

    hold_arm  = 1'b1;
    first_rnd = items;
    while (items - first_rnd < 88) begin
      if (items - first_rnd >= 60) begin
        src_idle = 0;
        snk_idle = 0;
      end else if (items - first_rnd >= 30) begin
        src_idle = 72;
        snk_idle = 32;
      end
      // one overflowing set: the count saturates at the store depth
      if (!big_done && items - first_rnd > 35) begin
        rand_set(MAX_POINTS + 2, 1'b1, 1'b1);
        send_col(MAX_POINTS - 1);
        big_done = 1'b1;
      end
      sel = $urandom_range(0, 9);
      n   = (sel == 0) ? $urandom_range(6, 10) : $urandom_range(2, 5);
      rand_set(n, sel != 1, sel != 2);
      repeat ($urandom_range(1, 3))
        send_col(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n - 1));
    end
    cmd.valid <= 1'b0;

    repeat (3) @(posedge clk);
    wait (pending == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d loads and %0d column requests; %0d entries compared, %0d error answers",
             loads, columns, checked, err_seen);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tmmi_pkg.sv
rtl/tmmi_in_if.sv
rtl/tmmi_out_if.sv
rtl/tmmi_div.sv
rtl/tridiagonal_mass_matrix_inverse.sv
dv/tmmi_column_checker.sv
dv/testbench.sv
